>>> hw/rtl/dmbm_pkg.sv
// Shared constants and register index codes for the display mode best match block.
// No dependencies; used by the channel interfaces and the top level.

package dmbm_pkg;

  localparam int unsigned DimBitsDefault = 16;
  localparam int unsigned IdW            = 32;
  localparam int unsigned DepthW         = 6;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned CfgDataW       = 16;

  localparam logic [DepthW-1:0] WantedDepthReset = DepthW'(16);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WANTED_WIDTH  = 2'd0,
    CFG_WANTED_HEIGHT = 2'd1,
    CFG_WANTED_DEPTH  = 2'd2
  } cfg_idx_e;

endpackage

>>> hw/rtl/dmbm_if.sv
// Valid/ready channel interfaces for candidate modes, match results and register writes.
// Depends on dmbm_pkg for field widths.

interface dmbm_mode_if #(
  parameter int unsigned DIM_BITS = dmbm_pkg::DimBitsDefault
);
  logic                       valid;
  logic                       ready;
  logic [dmbm_pkg::IdW-1:0]    mode_id;
  logic                       is_truecolor;
  logic [DIM_BITS-1:0]         mode_width;
  logic [DIM_BITS-1:0]         mode_height;
  logic [dmbm_pkg::DepthW-1:0] mode_depth;
  logic                       last_mode;

  modport source (
    output valid, mode_id, is_truecolor, mode_width, mode_height, mode_depth, last_mode,
    input  ready
  );
  modport sink (
    input  valid, mode_id, is_truecolor, mode_width, mode_height, mode_depth, last_mode,
    output ready
  );
endinterface

interface dmbm_result_if #(
  parameter int unsigned DIM_BITS = dmbm_pkg::DimBitsDefault
);
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [dmbm_pkg::IdW-1:0]    best_mode_id;
  logic [DIM_BITS-1:0]         best_width;
  logic [DIM_BITS-1:0]         best_height;
  logic [dmbm_pkg::DepthW-1:0] best_depth;

  modport source (
    output valid, found, best_mode_id, best_width, best_height, best_depth,
    input  ready
  );
  modport sink (
    input  valid, found, best_mode_id, best_width, best_height, best_depth,
    output ready
  );
endinterface

interface dmbm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dmbm_pkg::CfgIdxW-1:0]  index;
  logic [dmbm_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/display_mode_best_match.sv
// Top level of the display mode best match block.
// Depends on dmbm_pkg and the channel interfaces in dmbm_if.sv.

// Takes one candidate mode per clock while the pipe is not held and returns the
// best fit on the candidate flagged last once it has passed both stages. Stage one
// registers the candidate and forms its score (two absolute differences and one
// DIM_BITS x DIM_BITS multiply); stage two compares that score with the running
// best and updates it, so the best-so-far register loop holds only a compare and
// a select. The input stays open while a result waits in the output register;
// only a last candidate reaching stage two with that register still full holds
// the pipe. Register writes are taken at any time, but candidates already in
// the pipe see the new values, so writes belong between searches with the pipe
// empty.
module display_mode_best_match #(
  parameter int unsigned DIM_BITS = dmbm_pkg::DimBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dmbm_cfg_if.sink              cfg_i,
  dmbm_mode_if.sink             mode_i,
  dmbm_result_if.source         result_o
);

  localparam int unsigned ScoreW = 2 * DIM_BITS;
  localparam int unsigned IdW    = dmbm_pkg::IdW;
  localparam int unsigned DepthW = dmbm_pkg::DepthW;

  // configuration
  logic [DIM_BITS-1:0] wanted_w_q;
  logic [DIM_BITS-1:0] wanted_h_q;
  logic [DepthW-1:0]   wanted_d_q;

  // stage one: registered candidate
  logic                s1_valid_q;
  logic [IdW-1:0]      s1_id_q;
  logic                s1_tc_q;
  logic [DIM_BITS-1:0] s1_w_q;
  logic [DIM_BITS-1:0] s1_h_q;
  logic [DepthW-1:0]   s1_d_q;
  logic                s1_last_q;

  // stage two: scored candidate
  logic                s2_valid_q;
  logic [ScoreW-1:0]   s2_score_q;
  logic [IdW-1:0]      s2_id_q;
  logic                s2_tc_q;
  logic [DIM_BITS-1:0] s2_w_q;
  logic [DIM_BITS-1:0] s2_h_q;
  logic [DepthW-1:0]   s2_d_q;
  logic                s2_last_q;

  // running best
  logic [ScoreW-1:0]   best_score_q, best_score_d;
  logic [IdW-1:0]      best_id_q, best_id_d;
  logic [DIM_BITS-1:0] best_w_q, best_w_d;
  logic [DIM_BITS-1:0] best_h_q, best_h_d;
  logic [DepthW-1:0]   best_d_q, best_d_d;
  logic                have_best_q, have_best_d;

  // result register
  logic                out_valid_q;
  logic                out_found_q;
  logic [IdW-1:0]      out_id_q;
  logic [DIM_BITS-1:0] out_w_q;
  logic [DIM_BITS-1:0] out_h_q;
  logic [DepthW-1:0]   out_d_q;

  logic                out_free;
  logic                s2_fire;
  logic                s2_ready;
  logic                s1_ready;
  logic                in_fire;
  logic                s1_adv;

  logic [DIM_BITS-1:0] dist_w;
  logic [DIM_BITS-1:0] dist_h;
  logic [ScoreW-1:0]   score;

  logic                take;
  logic                lower;

  // handshake
  assign out_free = !out_valid_q || result_o.ready;
  assign s2_fire  = s2_valid_q && (!s2_last_q || out_free);
  assign s2_ready = !s2_valid_q || s2_fire;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_adv   = s1_valid_q && s2_ready;
  assign in_fire  = mode_i.valid && s1_ready;

  assign mode_i.ready = s1_ready;
  assign cfg_i.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_w_q <= '0;
      wanted_h_q <= '0;
      wanted_d_q <= dmbm_pkg::WantedDepthReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        dmbm_pkg::CFG_WANTED_WIDTH:  wanted_w_q <= cfg_i.data[DIM_BITS-1:0];
        dmbm_pkg::CFG_WANTED_HEIGHT: wanted_h_q <= cfg_i.data[DIM_BITS-1:0];
        dmbm_pkg::CFG_WANTED_DEPTH:  wanted_d_q <= cfg_i.data[DepthW-1:0];
        default: ;
      endcase
    end
  end

  // stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= mode_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_id_q   <= mode_i.mode_id;
      s1_tc_q   <= mode_i.is_truecolor;
      s1_w_q    <= mode_i.mode_width;
      s1_h_q    <= mode_i.mode_height;
      s1_d_q    <= mode_i.mode_depth;
      s1_last_q <= mode_i.last_mode;
    end
  end

  // score: exact match counts as distance one
  always_comb begin
    if (s1_w_q > wanted_w_q) begin
      dist_w = s1_w_q - wanted_w_q;
    end else if (s1_w_q < wanted_w_q) begin
      dist_w = wanted_w_q - s1_w_q;
    end else begin
      dist_w = DIM_BITS'(1);
    end
    if (s1_h_q > wanted_h_q) begin
      dist_h = s1_h_q - wanted_h_q;
    end else if (s1_h_q < wanted_h_q) begin
      dist_h = wanted_h_q - s1_h_q;
    end else begin
      dist_h = DIM_BITS'(1);
    end
    score = ScoreW'(dist_w) * ScoreW'(dist_h);
  end

  // stage two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_score_q <= score;
      s2_id_q    <= s1_id_q;
      s2_tc_q    <= s1_tc_q;
      s2_w_q     <= s1_w_q;
      s2_h_q     <= s1_h_q;
      s2_d_q     <= s1_d_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // compare with the running best
  always_comb begin
    lower = s2_tc_q && (s2_score_q < best_score_q);
    take  = lower;
    if (s2_tc_q && (s2_score_q == best_score_q)) begin
      if (best_d_q > wanted_d_q) begin
        take = (s2_d_q < best_d_q) && (s2_d_q >= wanted_d_q);
      end else if (best_d_q < wanted_d_q) begin
        take = s2_d_q > best_d_q;
      end
    end

    best_score_d = lower ? s2_score_q : best_score_q;
    best_w_d     = lower ? s2_w_q : best_w_q;
    best_h_d     = lower ? s2_h_q : best_h_q;
    best_id_d    = take ? s2_id_q : best_id_q;
    best_d_d     = take ? s2_d_q : best_d_q;
    have_best_d  = take || have_best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= '1;
      best_id_q    <= '0;
      best_w_q     <= '0;
      best_h_q     <= '0;
      best_d_q     <= '0;
      have_best_q  <= 1'b0;
    end else if (s2_fire) begin
      if (s2_last_q) begin
        // search ends, start over
        best_score_q <= '1;
        best_id_q    <= '0;
        best_w_q     <= '0;
        best_h_q     <= '0;
        best_d_q     <= '0;
        have_best_q  <= 1'b0;
      end else begin
        best_score_q <= best_score_d;
        best_id_q    <= best_id_d;
        best_w_q     <= best_w_d;
        best_h_q     <= best_h_d;
        best_d_q     <= best_d_d;
        have_best_q  <= have_best_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && s2_last_q) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_last_q) begin
      out_found_q <= have_best_d;
      out_id_q    <= have_best_d ? best_id_d : '0;
      out_w_q     <= have_best_d ? best_w_d : '0;
      out_h_q     <= have_best_d ? best_h_d : '0;
      out_d_q     <= have_best_d ? best_d_d : '0;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.found        = out_found_q;
  assign result_o.best_mode_id = out_id_q;
  assign result_o.best_width   = out_w_q;
  assign result_o.best_height  = out_h_q;
  assign result_o.best_depth   = out_d_q;

endmodule

>>> verif/display_mode_best_match_tb.sv
// Self-checking testbench for the display mode best match block.
// Depends on dmbm_pkg, the channel interfaces in dmbm_if.sv and the top level RTL.

module display_mode_best_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DimBits  = dmbm_pkg::DimBitsDefault;
  localparam int unsigned DimMax   = (1 << DimBits) - 1;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned DrainWait = 8;
  localparam logic [dmbm_pkg::CfgIdxW-1:0] CfgIdxSpare = dmbm_pkg::CfgIdxW'(3);

  typedef struct packed {
    logic [dmbm_pkg::IdW-1:0]    id;
    logic                        tc;
    logic [DimBits-1:0]          w;
    logic [DimBits-1:0]          h;
    logic [dmbm_pkg::DepthW-1:0] d;
    logic                        last;
  } mode_t;

  typedef struct packed {
    logic                        found;
    logic [dmbm_pkg::IdW-1:0]    id;
    logic [DimBits-1:0]          w;
    logic [DimBits-1:0]          h;
    logic [dmbm_pkg::DepthW-1:0] d;
  } match_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dmbm_cfg_if                         cfg_if ();
  dmbm_mode_if   #(.DIM_BITS(DimBits)) mode_if ();
  dmbm_result_if #(.DIM_BITS(DimBits)) res_if ();

  display_mode_best_match #(.DIM_BITS(DimBits)) i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .mode_i   (mode_if),
    .result_o (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers and the running best
  logic [DimBits-1:0]          want_w, want_h;
  logic [dmbm_pkg::DepthW-1:0] want_d;
  logic [31:0]                 run_score;
  logic [dmbm_pkg::IdW-1:0]    run_id;
  logic [DimBits-1:0]          run_w, run_h;
  logic [dmbm_pkg::DepthW-1:0] run_d;
  logic                        run_valid;

  match_t best_fit_q[$];
  match_t seen;

  int unsigned errors      = 0;
  int unsigned items_sent  = 0;
  int unsigned results_got = 0;
  int unsigned cfg_writes  = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req    = 1'b0;

  function automatic logic [31:0] axis_gap(logic [DimBits-1:0] a, logic [DimBits-1:0] b);
    if (a > b) return 32'(a - b);
    if (a < b) return 32'(b - a);
    return 32'd1;
  endfunction

  function automatic void clear_best();
    run_score = '1;
    run_id    = '0;
    run_w     = '0;
    run_h     = '0;
    run_d     = '0;
    run_valid = 1'b0;
  endfunction

  function automatic void judge_mode(mode_t m);
    logic [31:0] score;
    logic        take;
    take = 1'b0;
    if (m.tc) begin
      score = axis_gap(m.w, want_w) * axis_gap(m.h, want_h);
      if (score < run_score) begin
        run_score = score;
        run_w     = m.w;
        run_h     = m.h;
        take      = 1'b1;
      end else if (score == run_score) begin
        // depth tie-break, size stays with the mode that set the score
        if (run_d > want_d) begin
          take = (m.d < run_d) && (m.d >= want_d);
        end else if (run_d < want_d) begin
          take = (m.d > run_d);
        end
      end
      if (take) begin
        run_d     = m.d;
        run_id    = m.id;
        run_valid = 1'b1;
      end
    end
    if (m.last) begin
      if (run_valid) best_fit_q.push_back('{1'b1, run_id, run_w, run_h, run_d});
      else best_fit_q.push_back('0);
      clear_best();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen = '{res_if.found, res_if.best_mode_id, res_if.best_width, res_if.best_height,
               res_if.best_depth};
      results_got++;
      if (best_fit_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, seen);
        errors++;
      end else begin
        match_t want;
        want = best_fit_q.pop_front();
        check_field("found", 32'(want.found), 32'(seen.found));
        check_field("best_mode_id", want.id, seen.id);
        check_field("best_width", 32'(want.w), 32'(seen.w));
        check_field("best_height", 32'(want.h), 32'(seen.h));
        check_field("best_depth", 32'(want.d), 32'(seen.d));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (mode_if.valid && mode_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int unsigned style, style_left, hold_cnt;
    style      = 0;
    style_left = 0;
    hold_cnt   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        res_if.ready <= 1'b0;
      end else if (hold_req) begin
        res_if.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HoldLen) begin
          hold_cnt = 0;
          hold_req = 1'b0;
        end
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(20, 100);
        end
        style_left--;
        case (style)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= $urandom_range(0, 1);
          2:       res_if.ready <= (style_left % 4) != 0;
          default: res_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // sender gaps between bursts; called at a falling edge
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        mode_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_mode(input mode_t m, input bit paced = 1'b1);
    if (paced) pace();
    mode_if.valid        <= 1'b1;
    mode_if.mode_id      <= m.id;
    mode_if.is_truecolor <= m.tc;
    mode_if.mode_width   <= m.w;
    mode_if.mode_height  <= m.h;
    mode_if.mode_depth   <= m.d;
    mode_if.last_mode    <= m.last;
    @(posedge clk_i);
    while (!mode_if.ready) @(posedge clk_i);
    judge_mode(m);
    items_sent++;
    @(negedge clk_i);
  endtask

  // wait until every expected result is in and the pipe is empty
  task automatic settle();
    mode_if.valid <= 1'b0;
    @(negedge clk_i);
    while (best_fit_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dmbm_pkg::CfgIdxW-1:0] idx,
                           input logic [dmbm_pkg::CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      dmbm_pkg::CFG_WANTED_WIDTH:  want_w = value[DimBits-1:0];
      dmbm_pkg::CFG_WANTED_HEIGHT: want_h = value[DimBits-1:0];
      dmbm_pkg::CFG_WANTED_DEPTH:  want_d = value[dmbm_pkg::DepthW-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned h, input int unsigned d);
    settle();
    write_reg(dmbm_pkg::CFG_WANTED_WIDTH, dmbm_pkg::CfgDataW'(w));
    write_reg(dmbm_pkg::CFG_WANTED_HEIGHT, dmbm_pkg::CfgDataW'(h));
    write_reg(dmbm_pkg::CFG_WANTED_DEPTH, dmbm_pkg::CfgDataW'(d));
  endtask

  function automatic logic [DimBits-1:0] near_dim(logic [DimBits-1:0] target);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'(target) + int'($urandom_range(0, 8)) - 4;
      5, 6:          v = int'(target);
      7:             v = $urandom_range(0, 1) ? DimMax : 0;
      default:       v = int'($urandom_range(0, DimMax));
    endcase
    if (v < 0) v = 0;
    if (v > int'(DimMax)) v = DimMax;
    return DimBits'(v);
  endfunction

  function automatic logic [dmbm_pkg::DepthW-1:0] pick_depth();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 32;
      2, 3, 4: v = int'(want_d) + int'($urandom_range(0, 2)) - 1;
      default: v = $urandom_range(0, 32);
    endcase
    if (v < 0) v = 0;
    if (v > 32) v = 32;
    return dmbm_pkg::DepthW'(v);
  endfunction

  function automatic mode_t pick_mode();
    mode_t m;
    m.id   = $urandom();
    m.tc   = ($urandom_range(0, 7) != 0);
    m.w    = near_dim(want_w);
    m.h    = near_dim(want_h);
    m.d    = pick_depth();
    m.last = ($urandom_range(0, 40) == 0);
    return m;
  endfunction

  // candidate lists of random length, mostly short, ended by a last item
  task automatic run_lists(input int unsigned n_items);
    int unsigned start, len;
    mode_t m;
    start = items_sent;
    while (items_sent - start < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int unsigned i = 0; i < len; i++) begin
        m = pick_mode();
        if (i == len - 1) m.last = 1'b1;
        send_mode(m);
      end
    end
  endtask

  task automatic test_reset_values();
    run_lists(30);
  endtask

  task automatic test_spare_index();
    settle();
    write_reg(CfgIdxSpare, dmbm_pkg::CfgDataW'($urandom()));
    run_lists(20);
  endtask

  task automatic test_directed();
    mode_t list[$];
    apply_setting(640, 480, 16);
    // skipped mode only, then an exact match
    list.push_back('{32'd1, 1'b0, 16'd640, 16'd480, 6'd16, 1'b1});
    list.push_back('{32'd2, 1'b1, 16'd640, 16'd480, 6'd16, 1'b1});
    // field extremes
    list.push_back('{32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 6'd32, 1'b0});
    list.push_back('{32'd0, 1'b1, 16'd0, 16'd0, 6'd0, 1'b1});
    // best deeper than wanted: shallower but still deep enough wins the tie
    list.push_back('{32'd10, 1'b1, 16'd650, 16'd480, 6'd32, 1'b0});
    list.push_back('{32'd11, 1'b1, 16'd640, 16'd490, 6'd24, 1'b0});
    list.push_back('{32'd12, 1'b1, 16'd645, 16'd482, 6'd8, 1'b0});
    list.push_back('{32'd13, 1'b1, 16'd630, 16'd480, 6'd16, 1'b1});
    // best shallower than wanted: any deeper wins the tie
    list.push_back('{32'd20, 1'b1, 16'd641, 16'd481, 6'd8, 1'b0});
    list.push_back('{32'd21, 1'b1, 16'd639, 16'd479, 6'd12, 1'b0});
    list.push_back('{32'd22, 1'b1, 16'd640, 16'd480, 6'd10, 1'b0});
    list.push_back('{32'd23, 1'b1, 16'd639, 16'd481, 6'd4, 1'b1});
    // best at wanted depth keeps the tie; skipped mode ignored; last item judged too
    list.push_back('{32'd30, 1'b1, 16'd642, 16'd480, 6'd16, 1'b0});
    list.push_back('{32'd31, 1'b1, 16'd640, 16'd482, 6'd32, 1'b0});
    list.push_back('{32'd32, 1'b0, 16'd640, 16'd480, 6'd16, 1'b0});
    list.push_back('{32'd33, 1'b1, 16'd641, 16'd479, 6'd8, 1'b1});
    // worse score never replaces
    list.push_back('{32'd40, 1'b1, 16'd640, 16'd481, 6'd0, 1'b0});
    list.push_back('{32'd41, 1'b1, 16'd700, 16'd480, 6'd32, 1'b1});
    foreach (list[i]) send_mode(list[i]);
  endtask

  task automatic test_sweep();
    int unsigned corner_w[4] = '{0, DimMax, 0, DimMax};
    int unsigned corner_h[4] = '{0, DimMax, DimMax, 0};
    int unsigned corner_d[4] = '{0, 32, 1, 31};
    for (int i = 0; i < 4; i++) begin
      apply_setting(corner_w[i], corner_h[i], corner_d[i]);
      run_lists(120);
    end
    for (int i = 0; i < 4; i++) begin
      apply_setting($urandom_range(0, DimMax), $urandom_range(0, DimMax), $urandom_range(0, 32));
      run_lists(120);
    end
  endtask

  // long receiver hold-off while last items keep coming back to back
  task automatic test_backpressure();
    mode_t m;
    apply_setting(800, 600, 24);
    hold_req = 1'b1;
    for (int i = 0; i < 24; i++) begin
      m      = pick_mode();
      m.last = 1'b1;
      send_mode(m, 1'b0);
    end
    settle();
  endtask

  initial begin
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    mode_if.valid        = 1'b0;
    mode_if.mode_id      = '0;
    mode_if.is_truecolor = 1'b0;
    mode_if.mode_width   = '0;
    mode_if.mode_height  = '0;
    mode_if.mode_depth   = '0;
    mode_if.last_mode    = 1'b0;
    want_w = '0;
    want_h = '0;
    want_d = dmbm_pkg::WantedDepthReset;
    clear_best();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_spare_index();
    test_directed();
    test_backpressure();
    test_sweep();
    test_backpressure();

    settle();
    $display("covered %0d candidate modes, %0d best-match results, %0d register writes",
             items_sent, results_got, cfg_writes);
    $display("settings swept over size and depth corners plus random targets, %0d errors",
             errors);
    if (errors == 0 && best_fit_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
